// ----- hw/rtl/gbe_pkg.sv -----
// Shared types, constants and microprogram of the gap-buffer editor.
package gbe_pkg;

    localparam int BUF_SIZE = 1024;
    localparam int ADDR_W   = $clog2(BUF_SIZE);
    localparam int END_W    = ADDR_W + 1;
    localparam int CNT_W    = 12;
    localparam int CHAR_W   = 8;
    localparam int IDX_W    = 10;
    localparam int LEN_W    = 10;

    typedef enum logic [1:0] {
        F_INSERT = 2'd0,
        F_DELETE = 2'd1,
        F_MOVE   = 2'd2,
        F_READ   = 2'd3
    } func_t;

    // Microprogram steps; order matters for sequential fall-through.
    typedef enum logic [3:0] {
        UP_FETCH,
        UP_INS,
        UP_DEL,
        UP_MOVE,
        UP_RGT_RD,
        UP_RGT_WR,
        UP_LFT_RD,
        UP_LFT_WR,
        UP_READ,
        UP_READ_CAP,
        UP_POST
    } upc_t;

    typedef enum logic [2:0] {
        J_NEXT,   // fall through
        J_GOTO,   // go to target
        J_FETCH,  // hold until a word is taken, then dispatch on its function
        J_CHECK,  // fall through when the guard holds, else go to post
        J_SIGN,   // post when refused or zero, target when negative, else fall through
        J_LOOP,   // back to target while bytes remain, else go to post
        J_POST    // hold until the result slot frees, then fetch
    } jump_t;

    typedef enum logic [2:0] {
        AD_GS,
        AD_GS_M1,
        AD_GE,
        AD_GE_M1,
        AD_RIDX
    } addr_sel_t;

    typedef enum logic [2:0] {
        P_NONE,
        P_GS_INC,
        P_GS_SUB,
        P_BOTH_INC,
        P_BOTH_DEC
    } ptr_op_t;

    typedef struct packed {
        jump_t     jump;
        upc_t      target;
        logic      take;
        logic      chk;
        logic      gate;
        addr_sel_t addr;
        logic      rd;
        logic      wr;
        logic      wsel_char;
        ptr_op_t   ptr;
        logic      ld_mag;
        logic      cap_char;
    } ucw_t;

    typedef struct packed {
        logic              wr;
        logic [ADDR_W-1:0] wr_addr;
        logic [CHAR_W-1:0] wr_data;
        logic              rd;
        logic [ADDR_W-1:0] rd_addr;
    } mem_req_t;

    localparam ucw_t UCW_NOP = '{
        jump: J_NEXT, target: UP_FETCH, take: 1'b0, chk: 1'b0, gate: 1'b0,
        addr: AD_GS, rd: 1'b0, wr: 1'b0, wsel_char: 1'b0, ptr: P_NONE,
        ld_mag: 1'b0, cap_char: 1'b0
    };

    function automatic upc_t dispatch(input func_t f);
        upc_t u;
        case (f)
            F_INSERT: u = UP_INS;
            F_DELETE: u = UP_DEL;
            F_MOVE:   u = UP_MOVE;
            F_READ:   u = UP_READ;
            default:  u = UP_FETCH;
        endcase
        return u;
    endfunction

    // Control store: one control word per step.
    function automatic ucw_t ucode(input upc_t u);
        ucw_t w;
        w = UCW_NOP;
        case (u)
            UP_FETCH: begin
                w.jump = J_FETCH;
                w.take = 1'b1;
            end
            UP_INS: begin
                w.jump      = J_GOTO;
                w.target    = UP_POST;
                w.chk       = 1'b1;
                w.gate      = 1'b1;
                w.addr      = AD_GS;
                w.wr        = 1'b1;
                w.wsel_char = 1'b1;
                w.ptr       = P_GS_INC;
            end
            UP_DEL: begin
                w.jump   = J_GOTO;
                w.target = UP_POST;
                w.chk    = 1'b1;
                w.gate   = 1'b1;
                w.ptr    = P_GS_SUB;
            end
            UP_MOVE: begin
                w.jump   = J_SIGN;
                w.target = UP_LFT_RD;
                w.chk    = 1'b1;
                w.gate   = 1'b1;
                w.ld_mag = 1'b1;
            end
            UP_RGT_RD: begin
                w.addr = AD_GE;
                w.rd   = 1'b1;
            end
            UP_RGT_WR: begin
                w.jump   = J_LOOP;
                w.target = UP_RGT_RD;
                w.addr   = AD_GS;
                w.wr     = 1'b1;
                w.ptr    = P_BOTH_INC;
            end
            UP_LFT_RD: begin
                w.addr = AD_GS_M1;
                w.rd   = 1'b1;
            end
            UP_LFT_WR: begin
                w.jump   = J_LOOP;
                w.target = UP_LFT_RD;
                w.addr   = AD_GE_M1;
                w.wr     = 1'b1;
                w.ptr    = P_BOTH_DEC;
            end
            UP_READ: begin
                w.jump = J_CHECK;
                w.chk  = 1'b1;
                w.gate = 1'b1;
                w.addr = AD_RIDX;
                w.rd   = 1'b1;
            end
            UP_READ_CAP: begin
                w.jump     = J_GOTO;
                w.target   = UP_POST;
                w.cap_char = 1'b1;
            end
            UP_POST: begin
                w.jump = J_POST;
            end
            default: begin
                w.jump   = J_GOTO;
                w.target = UP_FETCH;
            end
        endcase
        return w;
    endfunction

endpackage

// ----- hw/rtl/gbe_text_mem.sv -----
// Text store: single-write, single-read byte memory with registered read data.
module gbe_text_mem (
    input  logic                           clk,
    input  gbe_pkg::mem_req_t              req,
    output logic [gbe_pkg::CHAR_W-1:0]     rd_data
);
    import gbe_pkg::*;

    logic [CHAR_W-1:0] mem [BUF_SIZE];

    always_ff @(posedge clk)
    begin
        if (req.wr)
        begin
            mem[req.wr_addr] <= req.wr_data;
        end
    end

    always_ff @(posedge clk)
    begin
        if (req.rd)
        begin
            rd_data <= mem[req.rd_addr];
        end
    end

endmodule

// ----- hw/rtl/gap_buffer_editor_core.sv -----
// Gap-buffer text editor core: microcoded sequencer over a byte text store.
//
//  channel  handshake            payload
//  -------  -------------------  ------------------------------------------------
//  input    in_valid / in_ready  func, char_in, step_count, read_index
//  output   out_valid/out_ready  ok, char_out, cursor_pos, text_length
//
// Each word passes through the fetch step, the step of its function and the
// post step; an accepted read adds a capture step, and an accepted nonzero move
// adds a copy loop over the text store: one read step and one write step per
// byte carried across the gap.
// A finished result sits in the output register; the next word is taken
// while it waits, and the sequencer only holds in its post step if the
// register is still full. Reset clears the cursor to zero, opens the gap over all
// but the last slot and empties the output register; the store is not cleared.
module gap_buffer_editor_core (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              in_valid,
    output logic                              in_ready,
    input  logic [1:0]                        func,
    input  logic [gbe_pkg::CHAR_W-1:0]        char_in,
    input  logic signed [gbe_pkg::CNT_W-1:0]  step_count,
    input  logic [gbe_pkg::IDX_W-1:0]         read_index,
    output logic                              out_valid,
    input  logic                              out_ready,
    output logic                              ok,
    output logic [gbe_pkg::CHAR_W-1:0]        char_out,
    output logic [gbe_pkg::LEN_W-1:0]         cursor_pos,
    output logic [gbe_pkg::LEN_W-1:0]         text_length
);
    import gbe_pkg::*;

    // Sequencer.
    upc_t upc_reg, upc_next;
    ucw_t cw;

    // Latched word.
    func_t             func_reg, func_next;
    logic [CHAR_W-1:0] char_reg, char_next;
    logic [CNT_W-1:0]  cnt_reg, cnt_next;
    logic [IDX_W-1:0]  idx_reg, idx_next;

    // Gap bounds and working registers.
    logic [ADDR_W-1:0] gs_reg, gs_next;
    logic [END_W-1:0]  ge_reg, ge_next;
    logic [CNT_W-1:0]  mag_reg, mag_next;
    logic              okf_reg, okf_next;
    logic [CHAR_W-1:0] rdc_reg, rdc_next;

    // Output register.
    logic              ov_reg, ov_next;
    logic              ok_reg, ok_next;
    logic [CHAR_W-1:0] co_reg, co_next;
    logic [LEN_W-1:0]  cur_reg, cur_next;
    logic [LEN_W-1:0]  len_reg, len_next;

    // Datapath terms.
    logic [END_W-1:0]  text_len;
    logic [CNT_W-1:0]  neg_cnt;
    logic              cnt_neg;
    logic              cnt_zero;
    logic [CNT_W:0]    right_end;
    logic [END_W-1:0]  far_addr;
    logic              cond;
    logic              act;
    logic              in_take;
    logic              slot_free;
    mem_req_t          mreq;
    logic [CHAR_W-1:0] rd_data;

    gbe_text_mem u_mem (
        .clk     (clk),
        .req     (mreq),
        .rd_data (rd_data)
    );

    assign cw        = ucode(upc_reg);
    assign in_ready  = cw.take;
    assign in_take   = in_valid && cw.take;
    assign slot_free = !ov_reg || out_ready;

    assign out_valid   = ov_reg;
    assign ok          = ok_reg;
    assign char_out    = co_reg;
    assign cursor_pos  = cur_reg;
    assign text_length = len_reg;

    // Text length: bytes before the gap plus bytes after it (last slot reserved).
    assign text_len  = {1'b0, gs_reg} + (END_W'(BUF_SIZE - 1) - ge_reg);
    assign cnt_neg   = cnt_reg[CNT_W-1];
    assign cnt_zero  = (cnt_reg == '0);
    assign neg_cnt   = ~cnt_reg + CNT_W'(1);
    assign right_end = {{(CNT_W + 1 - END_W){1'b0}}, ge_reg} + {1'b0, cnt_reg};
    assign far_addr  = ge_reg + {1'b0, idx_reg} - {1'b0, gs_reg};

    // Guard of the current function.
    always_comb
    begin
        case (func_reg)
            F_INSERT: cond = ({1'b0, gs_reg} + END_W'(1)) < ge_reg;
            F_DELETE: cond = !cnt_neg && (cnt_reg <= CNT_W'(gs_reg));
            F_MOVE:
            begin
                if (cnt_zero)
                begin
                    cond = 1'b1;
                end
                else if (cnt_neg)
                begin
                    cond = neg_cnt <= CNT_W'(gs_reg);
                end
                else
                begin
                    cond = right_end <= (CNT_W + 1)'(BUF_SIZE - 1);
                end
            end
            F_READ:   cond = {1'b0, idx_reg} < text_len;
            default:  cond = 1'b0;
        endcase
    end

    assign act = !cw.gate || cond;

    // Memory request.
    always_comb
    begin
        mreq.wr      = cw.wr && act;
        mreq.rd      = cw.rd && act;
        mreq.wr_data = cw.wsel_char ? char_reg : rd_data;
        mreq.wr_addr = gs_reg;
        mreq.rd_addr = gs_reg;
        case (cw.addr)
            AD_GS:    mreq.wr_addr = gs_reg;
            AD_GE_M1: mreq.wr_addr = ge_reg[ADDR_W-1:0] - ADDR_W'(1);
            default:  mreq.wr_addr = gs_reg;
        endcase
        case (cw.addr)
            AD_GE:    mreq.rd_addr = ge_reg[ADDR_W-1:0];
            AD_GS_M1: mreq.rd_addr = gs_reg - ADDR_W'(1);
            AD_RIDX:
            begin
                // Below the cursor read in place; at or above it skip the gap.
                if (idx_reg < gs_reg)
                begin
                    mreq.rd_addr = idx_reg;
                end
                else
                begin
                    mreq.rd_addr = far_addr[ADDR_W-1:0];
                end
            end
            default:  mreq.rd_addr = gs_reg;
        endcase
    end

    // Next step, datapath updates and result posting.
    always_comb
    begin
        upc_next  = upc_reg;
        func_next = func_reg;
        char_next = char_reg;
        cnt_next  = cnt_reg;
        idx_next  = idx_reg;
        gs_next   = gs_reg;
        ge_next   = ge_reg;
        mag_next  = mag_reg;
        okf_next  = okf_reg;
        rdc_next  = rdc_reg;
        ov_next   = ov_reg;
        ok_next   = ok_reg;
        co_next   = co_reg;
        cur_next  = cur_reg;
        len_next  = len_reg;

        if (ov_reg && out_ready)
        begin
            ov_next = 1'b0;
        end

        if (in_take)
        begin
            func_next = func_t'(func);
            char_next = char_in;
            cnt_next  = step_count;
            idx_next  = read_index;
            rdc_next  = '0;
        end

        if (cw.chk)
        begin
            okf_next = cond;
        end

        if (cw.ld_mag && act)
        begin
            mag_next = cnt_neg ? neg_cnt : cnt_reg;
        end

        if (cw.cap_char)
        begin
            rdc_next = rd_data;
        end

        if (act)
        begin
            case (cw.ptr)
                P_GS_INC:   gs_next = gs_reg + ADDR_W'(1);
                P_GS_SUB:   gs_next = gs_reg - cnt_reg[ADDR_W-1:0];
                P_BOTH_INC:
                begin
                    gs_next  = gs_reg + ADDR_W'(1);
                    ge_next  = ge_reg + END_W'(1);
                    mag_next = mag_reg - CNT_W'(1);
                end
                P_BOTH_DEC:
                begin
                    gs_next  = gs_reg - ADDR_W'(1);
                    ge_next  = ge_reg - END_W'(1);
                    mag_next = mag_reg - CNT_W'(1);
                end
                default:    gs_next = gs_reg;
            endcase
        end

        case (cw.jump)
            J_NEXT:  upc_next = upc_t'(upc_reg + 4'd1);
            J_GOTO:  upc_next = cw.target;
            J_FETCH:
            begin
                if (in_take)
                begin
                    upc_next = dispatch(func_t'(func));
                end
            end
            J_CHECK: upc_next = cond ? upc_t'(upc_reg + 4'd1) : UP_POST;
            J_SIGN:
            begin
                if (!cond || cnt_zero)
                begin
                    upc_next = UP_POST;
                end
                else if (cnt_neg)
                begin
                    upc_next = cw.target;
                end
                else
                begin
                    upc_next = upc_t'(upc_reg + 4'd1);
                end
            end
            J_LOOP:  upc_next = (mag_reg != CNT_W'(1)) ? cw.target : UP_POST;
            J_POST:
            begin
                // Hold until the output register can take the result.
                if (slot_free)
                begin
                    ov_next  = 1'b1;
                    ok_next  = okf_reg;
                    co_next  = rdc_reg;
                    cur_next = LEN_W'(gs_reg);
                    len_next = text_len[LEN_W-1:0];
                    upc_next = UP_FETCH;
                end
            end
            default: upc_next = UP_FETCH;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            upc_reg <= UP_FETCH;
            gs_reg  <= '0;
            ge_reg  <= END_W'(BUF_SIZE - 1);
            ov_reg  <= 1'b0;
            okf_reg <= 1'b0;
        end
        else
        begin
            upc_reg <= upc_next;
            gs_reg  <= gs_next;
            ge_reg  <= ge_next;
            ov_reg  <= ov_next;
            okf_reg <= okf_next;
        end
    end

    always_ff @(posedge clk)
    begin
        func_reg <= func_next;
        char_reg <= char_next;
        cnt_reg  <= cnt_next;
        idx_reg  <= idx_next;
        mag_reg  <= mag_next;
        rdc_reg  <= rdc_next;
        ok_reg   <= ok_next;
        co_reg   <= co_next;
        cur_reg  <= cur_next;
        len_reg  <= len_next;
    end

endmodule

// ----- tb/sv/tb_top.sv -----
// Self-checking testbench for the gap-buffer editor core: driver, monitor and edit predictor.
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    import gbe_pkg::*;

    // Run shape
    localparam int RAND_WORDS   = 1450;               // random words before the run may stop
    localparam int PHASE_WORDS  = 480;                // random words per idling phase
    localparam int FULL_LEN     = BUF_SIZE - 2;       // longest text the store can hold
    localparam int PAST_FULL    = 25;                 // insert-heavy words kept up once full
    localparam int HOLD_CYCLES  = 300;                // long receiver hold-off
    localparam int DRAIN_CYCLES = 3 + 2 * BUF_SIZE;   // longest move the block can run
    localparam int REPORT_MAX   = 10;

    typedef enum {GM_GROW, GM_MIX, GM_TRIM} gen_mode_t;

    // One input word as it goes on the bus
    typedef struct packed {
        func_t                    op;
        logic [CHAR_W-1:0]        ch;
        logic signed [CNT_W-1:0]  cnt;
        logic [IDX_W-1:0]         idx;
    } edit_word_t;

    // One reply word as the block should return it
    typedef struct packed {
        logic              ok;
        logic [CHAR_W-1:0] ch;
        logic [LEN_W-1:0]  cur;
        logic [LEN_W-1:0]  len;
    } text_reply_t;

    // Clock, reset and block ports; every input starts at a known value
    logic                     clk        = 1'b0;
    logic                     rst_n      = 1'b0;
    logic                     in_valid   = 1'b0;
    logic                     in_ready;
    logic [1:0]               func       = 2'd0;
    logic [CHAR_W-1:0]        char_in    = '0;
    logic signed [CNT_W-1:0]  step_count = '0;
    logic [IDX_W-1:0]         read_index = '0;
    logic                     out_valid;
    logic                     out_ready  = 1'b0;
    logic                     ok;
    logic [CHAR_W-1:0]        char_out;
    logic [LEN_W-1:0]         cursor_pos;
    logic [LEN_W-1:0]         text_length;

    // Words waiting to be sent and replies waiting to arrive
    edit_word_t  pending_words [$];
    text_reply_t awaited_replies [$];

    // Predicted editor state: text store, gap start (cursor) and gap end
    bit [CHAR_W-1:0] txt [BUF_SIZE];
    int gs = 0;
    int ge = BUF_SIZE - 1;

    // Traffic control shared by the processes
    int   snd_idle_pct = 38;
    int   rcv_idle_pct = 48;
    logic hold_go      = 1'b0;
    int   hold_left;

    // Statistics and failures
    int mismatch_cnt = 0;
    int op_seen [4]  = '{default: 0};
    int refused_cnt  = 0;
    int peak_len     = 0;
    int widest_move  = 0;

    edit_word_t  nxt;
    text_reply_t got_reply;
    text_reply_t want_reply;

    gap_buffer_editor_core uut (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .func        (func),
        .char_in     (char_in),
        .step_count  (step_count),
        .read_index  (read_index),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .ok          (ok),
        .char_out    (char_out),
        .cursor_pos  (cursor_pos),
        .text_length (text_length)
    );

    always #6 clk = ~clk;

    // Number of text bytes held: left part plus right part of the store
    function automatic int held_len();
        return gs + BUF_SIZE - 1 - ge;
    endfunction

    // Apply one edit word to the predicted state and return the reply it must produce.
    // A refused word leaves the state alone and reports it with a zero byte.
    function automatic text_reply_t apply_edit(input func_t op, input logic [CHAR_W-1:0] ch,
                                               input logic signed [CNT_W-1:0] cnt,
                                               input logic [IDX_W-1:0] idx);
        text_reply_t r;
        int n;
        int k;
        r = '0;
        n = int'(cnt);
        case (op)
            F_INSERT:
                // keep at least one free slot between the two parts
                if (gs + 1 < ge)
                begin
                    txt[gs] = ch;
                    gs++;
                    r.ok = 1'b1;
                end
            F_DELETE:
                if (n >= 0 && n <= gs)
                begin
                    gs -= n;
                    r.ok = 1'b1;
                end
            F_MOVE:
            begin
                if (n > 0 && ge + n <= BUF_SIZE - 1)
                begin
                    // carry bytes from the right part down to the cursor
                    for (k = 0; k < n; k++)
                        txt[gs + k] = txt[ge + k];
                    gs += n;
                    ge += n;
                    r.ok = 1'b1;
                end
                else if (n < 0 && -n <= gs)
                begin
                    // carry bytes below the cursor up under the right part
                    for (k = 0; k < -n; k++)
                        txt[ge - 1 - k] = txt[gs - 1 - k];
                    gs += n;
                    ge += n;
                    r.ok = 1'b1;
                end
                else if (n == 0)
                    r.ok = 1'b1;
                if (r.ok && (n < 0 ? -n : n) > widest_move)
                    widest_move = (n < 0) ? -n : n;
            end
            default:
                if (idx < held_len())
                begin
                    r.ch = (idx < gs) ? txt[idx] : txt[ge + idx - gs];
                    r.ok = 1'b1;
                end
        endcase
        k = held_len();
        r.cur = gs[LEN_W-1:0];
        r.len = k[LEN_W-1:0];
        return r;
    endfunction

    // Driver: predict each word at the edge that takes it, then offer the next one.
    // Hold valid and payload steady while the block is not ready.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid   <= 1'b0;
            func       <= F_INSERT;
            char_in    <= '0;
            step_count <= '0;
            read_index <= '0;
        end
        else
        begin
            if (in_valid && in_ready)
            begin
                got_reply = apply_edit(func_t'(func), char_in, step_count, read_index);
                awaited_replies.push_back(got_reply);
                op_seen[func]++;
                if (!got_reply.ok)
                    refused_cnt++;
                if (got_reply.len > peak_len)
                    peak_len = int'(got_reply.len);
            end
            if (!in_valid || in_ready)
            begin
                if (pending_words.size() != 0 && $urandom_range(99) >= snd_idle_pct)
                begin
                    nxt = pending_words.pop_front();
                    in_valid   <= 1'b1;
                    func       <= nxt.op;
                    char_in    <= nxt.ch;
                    step_count <= nxt.cnt;
                    read_index <= nxt.idx;
                end
                else
                    in_valid <= 1'b0;
            end
        end
    end

    // Receiver hold-off counter: load on request, count down to zero
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            hold_left <= 0;
        else if (hold_go)
            hold_left <= HOLD_CYCLES;
        else if (hold_left != 0)
            hold_left <= hold_left - 1;
    end

    // Monitor: compare every reply word with the oldest prediction, field by field
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_ready <= 1'b0;
        else
        begin
            if (out_valid && out_ready)
            begin
                if (awaited_replies.size() == 0)
                begin
                    mismatch_cnt++;
                    if (mismatch_cnt <= REPORT_MAX)
                        $display("%0t: reply with none awaited: ok=%0d char=%02h cur=%0d",
                                 $realtime, ok, char_out, cursor_pos, " len=%0d",
                                 text_length);
                end
                else
                begin
                    want_reply = awaited_replies.pop_front();
                    if (ok !== want_reply.ok || char_out !== want_reply.ch ||
                        cursor_pos !== want_reply.cur || text_length !== want_reply.len)
                    begin
                        mismatch_cnt++;
                        if (mismatch_cnt <= REPORT_MAX)
                        begin
                            $write("%0t: want ok=%0d char=%02h cur=%0d len=%0d, ",
                                   $realtime, want_reply.ok, want_reply.ch, want_reply.cur,
                                   want_reply.len);
                            $display("got ok=%0d char=%02h cur=%0d len=%0d",
                                     ok, char_out, cursor_pos, text_length);
                        end
                    end
                end
            end
            out_ready <= (hold_left == 0) && ($urandom_range(99) >= rcv_idle_pct);
        end
    end

    task automatic queue_word(input func_t op, input logic [CHAR_W-1:0] ch, input int cnt,
                              input int idx);
        edit_word_t w;
        w.op  = op;
        w.ch  = ch;
        w.cnt = cnt[CNT_W-1:0];
        w.idx = idx[IDX_W-1:0];
        pending_words.push_back(w);
    endtask

    // Wait until the block has taken every queued word, so the predicted state is current
    task automatic wait_sent();
        while (pending_words.size() != 0 || in_valid)
            @(negedge clk);
    endtask

    // Wait until every reply has come back as well
    task automatic wait_drained();
        wait_sent();
        while (awaited_replies.size() != 0)
            @(negedge clk);
    endtask

    // Build one random word. Grow mode types text with a few small edits mixed in;
    // mix and trim modes hit the bounds, long moves and large deletes.
    task automatic make_word(input gen_mode_t mode);
        int    pick;
        int    sub;
        int    room;
        int    cnt;
        int    idx;
        func_t op;
        pick = $urandom_range(99);
        sub  = $urandom_range(99);
        if (mode == GM_GROW)
            op = (pick < 90) ? F_INSERT : (pick < 94) ? F_READ : (pick < 98) ? F_MOVE : F_DELETE;
        else if (mode == GM_MIX)
            op = (pick < 35) ? F_INSERT : (pick < 55) ? F_READ : (pick < 80) ? F_MOVE : F_DELETE;
        else
            op = (pick < 15) ? F_INSERT : (pick < 40) ? F_READ : (pick < 70) ? F_MOVE : F_DELETE;
        // unused fields still carry noise, so every bit toggles
        cnt = $urandom_range(2048) - 1024;
        idx = $urandom_range(1023);
        case (op)
            F_MOVE:
                if (mode == GM_GROW || sub < 70)
                    cnt = $urandom_range(16) - 8;
                else if (sub < 96)
                begin
                    if (sub < 88)
                        wait_sent();
                    room = BUF_SIZE - 1 - ge;
                    if (sub < 80)
                        cnt = $urandom_range(1) ? room : -gs;              // exactly to an end
                    else if (sub < 88)
                        cnt = $urandom_range(1) ? room + 1 : -(gs + 1);    // one past an end
                    else
                        cnt = $urandom_range(room + gs) - gs;
                end
            F_DELETE:
                if (mode == GM_GROW)
                    cnt = $urandom_range(2);
                else if (sub < 90)
                begin
                    if (sub >= 50 && sub < 80)
                        wait_sent();
                    if (sub < 50)
                        cnt = $urandom_range(gs < 16 ? gs : 16);
                    else if (sub < 70)
                        cnt = gs;                                          // clear up to cursor
                    else if (sub < 80)
                        cnt = gs + 1;                                      // one too many
                    else
                        cnt = $urandom_range(gs);
                end
            F_READ:
                if (sub < 80)
                    idx = (held_len() > 0) ? $urandom_range(held_len() - 1) : 0;
                else if (sub < 88)
                begin
                    wait_sent();
                    idx = held_len();                                      // first index past text
                end
            default:
                ;
        endcase
        queue_word(op, CHAR_W'($urandom_range(255)), cnt, idx);
    endtask

    // Stimulus: reset, directed words, then three idling phases of random words
    initial
    begin
        int        rand_cnt;
        int        past_full;
        gen_mode_t mode;
        past_full = 0;
        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // Boundaries on an empty text
        queue_word(F_READ,   8'h00, 0, 0);
        queue_word(F_DELETE, 8'h00, 0, 0);
        queue_word(F_DELETE, 8'h00, -1, 0);
        queue_word(F_DELETE, 8'h00, 1, 0);
        queue_word(F_MOVE,   8'h00, 0, 0);
        queue_word(F_MOVE,   8'h00, 1, 0);
        queue_word(F_MOVE,   8'h00, -1, 0);
        // Type four bytes, then walk the cursor across them
        queue_word(F_INSERT, 8'h00, 0, 0);
        queue_word(F_INSERT, 8'hFF, 0, 0);
        queue_word(F_INSERT, 8'hA5, 0, 0);
        queue_word(F_INSERT, 8'h5A, 0, 0);
        queue_word(F_MOVE,   8'h00, -3, 0);
        queue_word(F_MOVE,   8'h00, -2, 0);
        queue_word(F_READ,   8'h00, 0, 0);
        queue_word(F_READ,   8'h00, 0, 3);
        queue_word(F_READ,   8'h00, 0, 4);
        // Right bound: one past the end is refused, exactly to the end is taken
        queue_word(F_MOVE,   8'h00, 4, 0);
        queue_word(F_MOVE,   8'h00, 3, 0);
        queue_word(F_MOVE,   8'h00, -1024, 0);
        queue_word(F_MOVE,   8'h00, 1024, 0);
        queue_word(F_MOVE,   8'h00, -4, 0);
        queue_word(F_INSERT, 8'h3C, 0, 0);
        queue_word(F_DELETE, 8'h00, 1024, 0);
        queue_word(F_MOVE,   8'h00, 4, 0);
        queue_word(F_DELETE, 8'h00, 5, 0);
        queue_word(F_READ,   8'h00, 0, 1023);
        // Pause the sender until every reply is back
        wait_drained();

        for (rand_cnt = 0; (rand_cnt < RAND_WORDS || past_full < PAST_FULL) && rand_cnt < 4000;
             rand_cnt++)
        begin
            if (rand_cnt == PHASE_WORDS)
            begin
                // drain, then swap the idling of the two sides
                wait_drained();
                snd_idle_pct = 48;
                rcv_idle_pct = 38;
            end
            if (rand_cnt == 2 * PHASE_WORDS)
            begin
                // no idling from here; open with a long receiver hold-off
                snd_idle_pct = 0;
                rcv_idle_pct = 0;
                hold_go = 1'b1;
                @(negedge clk);
                hold_go = 1'b0;
            end
            while (pending_words.size() != 0)
                @(negedge clk);
            if (peak_len < FULL_LEN)
                mode = GM_GROW;
            else if (past_full < PAST_FULL)
            begin
                mode = GM_GROW;
                past_full++;
            end
            else
                mode = $urandom_range(1) ? GM_MIX : GM_TRIM;
            make_word(mode);
        end

        wait_drained();
        repeat (DRAIN_CYCLES) @(negedge clk);
        $display("covered %0d words: %0d insert, %0d delete, %0d move, %0d read; %0d refused",
                 op_seen[0] + op_seen[1] + op_seen[2] + op_seen[3], op_seen[F_INSERT],
                 op_seen[F_DELETE], op_seen[F_MOVE], op_seen[F_READ], refused_cnt);
        $display("text peaked at %0d bytes, widest cursor move %0d, %0d mismatches",
                 peak_len, widest_move, mismatch_cnt);
        if (mismatch_cnt == 0 && awaited_replies.size() == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

    // Watchdog: several times the slowest legal run
    initial
    begin
        #6_000_000;
        $display("timeout with %0d replies outstanding", awaited_replies.size());
        $display("end of test: mismatches");
        $finish;
    end

endmodule
